// ===== rtl/imu_gravity_drift_integrator_macros.svh =====
// assertion macros shared by the rtl files of the imu gravity drift integrator
`ifndef IMU_GRAVITY_DRIFT_INTEGRATOR_MACROS_SVH
`define IMU_GRAVITY_DRIFT_INTEGRATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define IGDI_ASSERT_IMP(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("igdi same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define IGDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("igdi next-cycle check failed");

`else

`define IGDI_ASSERT_IMP(label, clk, rst, ante, cons)
`define IGDI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/igdi_pkg.sv =====
// shared constants, types and helpers of the imu gravity drift integrator
package igdi_pkg;

    // sample and fixed point formats
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int FIX_W     = SAMPLE_W + FRAC_BITS;
    localparam int DIFF_W    = FIX_W + 1;
    localparam int OUT_W     = DIFF_W;
    localparam int SUM_W     = 48;
    localparam int DT_W      = 16;

    // q0.16 weights
    localparam int Q_W = 16;
    localparam logic [Q_W:0] Q_ONE = (Q_W + 1)'(1) << Q_W;

    // bit-serial multiplier sizes
    localparam int MCAND_W   = 42;
    localparam int MPLIER_W  = Q_W + 1;
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int MUL_STEPS = MPLIER_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] ALPHA_RESET = 16'd64881;
    localparam logic [CFG_DATA_W-1:0] BETA_RESET  = 16'd64881;
    localparam logic [CFG_DATA_W-1:0] THR_RESET   = 16'd1108;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_ALPHA   = 2'd0,
        CFG_VELOCITY_BETA   = 2'd1,
        CFG_DRIFT_THRESHOLD = 2'd2
    } igdi_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_WB,
        ST_DONE
    } igdi_state_t;

    // one multiply per op, in this order
    typedef enum logic [3:0] {
        OP_LP_X     = 4'd0,
        OP_LP_Y     = 4'd1,
        OP_LP_Z     = 4'd2,
        OP_LP_DRIFT = 4'd3,
        OP_VB_X     = 4'd4,
        OP_VD_X     = 4'd5,
        OP_VB_Y     = 4'd6,
        OP_VD_Y     = 4'd7,
        OP_VB_Z     = 4'd8,
        OP_VD_Z     = 4'd9,
        OP_ANGLE    = 4'd10
    } igdi_op_t;

    typedef struct packed {
        logic     in_ready;
        logic     start;
        logic     wb;
        logic     out_load;
        igdi_op_t op;
    } igdi_ctrl_t;

    // clamp a sum that grew by one bit back to the signed sum range
    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] s);
        logic [SUM_W-1:0] r;
        if (s[SUM_W] != s[SUM_W-1])
        begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/igdi_sample_if.sv =====
// input sample channel
interface igdi_sample_if;
    import igdi_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x_raw;
    logic signed [SAMPLE_W-1:0] accel_y_raw;
    logic signed [SAMPLE_W-1:0] accel_z_raw;
    logic signed [SAMPLE_W-1:0] rate_x_raw;
    logic        [DT_W-1:0]     elapsed_ms;

    modport source (
        output valid, accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, elapsed_ms,
        output ready
    );
endinterface

// ===== rtl/igdi_result_if.sv =====
// result channel
interface igdi_result_if;
    import igdi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] linear_accel_x;
    logic signed [OUT_W-1:0] linear_accel_y;
    logic signed [OUT_W-1:0] linear_accel_z;
    logic signed [OUT_W-1:0] rate_corrected;
    logic signed [SUM_W-1:0] velocity_x;
    logic signed [SUM_W-1:0] velocity_y;
    logic signed [SUM_W-1:0] velocity_z;
    logic signed [SUM_W-1:0] angle_sum;

    modport source (
        output valid, linear_accel_x, linear_accel_y, linear_accel_z, rate_corrected,
               velocity_x, velocity_y, velocity_z, angle_sum,
        input  ready
    );
    modport sink (
        input  valid, linear_accel_x, linear_accel_y, linear_accel_z, rate_corrected,
               velocity_x, velocity_y, velocity_z, angle_sum,
        output ready
    );
endinterface

// ===== rtl/igdi_cfg_if.sv =====
// configuration write channel
interface igdi_cfg_if;
    import igdi_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/igdi_serial_mul.sv =====
// bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle
`include "imu_gravity_drift_integrator_macros.svh"

module igdi_serial_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [igdi_pkg::MCAND_W-1:0]   mcand,
    input  logic [igdi_pkg::MPLIER_W-1:0]  mplier,
    output logic                           busy,
    output logic                           done,
    output logic [igdi_pkg::PROD_W-1:0]    prod
);
    import igdi_pkg::*;

    logic [MCAND_W-1:0]   mcand_reg;
    logic [MCAND_W:0]     hi_reg;
    logic [MPLIER_W-1:0]  lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MCAND_W:0]     addend;
    logic [MCAND_W:0]     sum;
    logic [MCAND_W+MPLIER_W:0] full;
    logic                 last_step;

    // partial product add for the current multiplier bit
    always_comb
    begin
        addend = lo_reg[0] ? {mcand_reg[MCAND_W-1], mcand_reg} : '0;
        sum    = hi_reg + addend;
    end

    assign last_step = (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1));

    // product shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[MCAND_W], sum[MCAND_W:1]};
            lo_reg <= {sum[0], lo_reg[MPLIER_W-1:1]};
        end
    end

    // step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= last_step ? cnt_reg : cnt_reg + 1'b1;
            busy_reg <= !last_step;
            done_reg <= last_step;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign full = {hi_reg, lo_reg};
    assign prod = full[PROD_W-1:0];
    assign busy = busy_reg;
    assign done = done_reg;

    `IGDI_ASSERT_IMP(a_start_when_idle, clk, rst_n, start, !busy_reg)
    `IGDI_ASSERT_NEXT(a_start_runs, clk, rst_n, start, busy_reg && (cnt_reg == '0))
    `IGDI_ASSERT_IMP(a_done_ends_run, clk, rst_n, done_reg, !busy_reg)

endmodule

// ===== rtl/igdi_seq.sv =====
// sequencer stepping one sample through the eleven serial multiplies
module igdi_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 mul_done,
    input  logic                 out_free,
    output igdi_pkg::igdi_ctrl_t ctrl
);
    import igdi_pkg::*;

    igdi_state_t state_reg;
    igdi_state_t state_next;
    igdi_op_t    op_reg;
    igdi_op_t    op_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                    op_next    = OP_LP_X;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (op_reg == OP_ANGLE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOAD;
                    op_next    = igdi_op_t'(op_reg + 1'b1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.start    = (state_reg == ST_LOAD);
        ctrl.wb       = (state_reg == ST_WB);
        ctrl.out_load = (state_reg == ST_DONE) && out_free;
        ctrl.op       = op_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_LP_X;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

// ===== rtl/imu_gravity_drift_integrator.sv =====
// top level: imu gravity removal, drift removal and velocity/angle integration
//
// Takes one raw sample (three accelerations, one rate, elapsed ms) at a time and
// returns one result per sample. All products go through a single bit-serial
// multiplier that handles one multiplier bit per cycle over 17 steps; a product
// passes through load, multiply steps, done and writeback. A sample needs
// 11 products (four low-pass updates, two per velocity axis, one for the angle),
// and the result goes to the output register after the last writeback. The next
// sample can be taken in the cycle after the result has been moved into the
// output register, so a new sample waits until the previous one is done. When
// the previous result is still waiting in the output register, the block holds
// the finished result until that one is taken. Gravity, drift, velocity and
// angle state reset to zero; velocity and angle saturate at 48 bits. Values are
// raw LSB with 8 fraction bits, the weights are q0.16. Configuration writes are
// always accepted and must only be issued while no sample is in flight.
`include "imu_gravity_drift_integrator_macros.svh"

module imu_gravity_drift_integrator (
    input  logic          clk,
    input  logic          rst_n,
    igdi_sample_if.sink   sample,
    igdi_result_if.source result,
    igdi_cfg_if.sink      cfg
);
    import igdi_pkg::*;

    igdi_ctrl_t ctrl;

    // configuration registers
    logic [CFG_DATA_W-1:0] alpha_reg;
    logic [CFG_DATA_W-1:0] beta_reg;
    logic [CFG_DATA_W-1:0] thr_reg;

    // captured sample
    logic [FIX_W-1:0] x_reg [3];
    logic [FIX_W-1:0] rate_reg;
    logic [DT_W-1:0]  dt_reg;
    logic             learn_reg;

    // filter and integrator state
    logic [FIX_W-1:0] grav_reg [3];
    logic [FIX_W-1:0] drift_reg;
    logic [SUM_W-1:0] vel_reg [3];
    logic [SUM_W-1:0] angle_reg;

    // per-sample results
    logic [OUT_W-1:0] lin_reg [3];
    logic [OUT_W-1:0] corr_reg;

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_lin_reg [3];
    logic [OUT_W-1:0] out_corr_reg;
    logic [SUM_W-1:0] out_vel_reg [3];
    logic [SUM_W-1:0] out_angle_reg;

    logic sample_xfer;
    logic result_xfer;
    logic out_free;

    logic [SAMPLE_W:0] rate_ext;
    logic [SAMPLE_W:0] rate_mag;
    logic              learn_c;

    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
    logic [MPLIER_W-1:0] one_minus_beta;
    logic                mul_busy;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_prod;

    logic [1:0]        axis;
    logic [FIX_W-1:0]  lp_est;
    logic [FIX_W-1:0]  lp_x;
    logic [DIFF_W-1:0] lp_diff;
    logic [DIFF_W-1:0] lp_t;
    logic [FIX_W-1:0]  lp_new;
    logic [DIFF_W-1:0] lp_lin;
    logic [MCAND_W-1:0] vd_inc;
    logic [SUM_W:0]    vel_sum;
    logic [SUM_W:0]    ang_sum;

    assign sample_xfer = sample.valid && sample.ready;
    assign result_xfer = result.valid && result.ready;
    assign out_free    = !out_valid_reg || result.ready;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
            thr_reg   <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GRAVITY_ALPHA:   alpha_reg <= cfg.data;
                CFG_VELOCITY_BETA:   beta_reg  <= cfg.data;
                CFG_DRIFT_THRESHOLD: thr_reg   <= cfg.data;
                default:             ;
            endcase
        end
    end

    // drift is learned while the raw rate magnitude is below the threshold
    always_comb
    begin
        rate_ext = {sample.rate_x_raw[SAMPLE_W-1], sample.rate_x_raw};
        rate_mag = rate_ext[SAMPLE_W] ? (~rate_ext + 1'b1) : rate_ext;
        learn_c  = rate_mag < {1'b0, thr_reg};
    end

    // sample capture on transfer
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            x_reg[0]  <= {sample.accel_x_raw, {FRAC_BITS{1'b0}}};
            x_reg[1]  <= {sample.accel_y_raw, {FRAC_BITS{1'b0}}};
            x_reg[2]  <= {sample.accel_z_raw, {FRAC_BITS{1'b0}}};
            rate_reg  <= {sample.rate_x_raw, {FRAC_BITS{1'b0}}};
            dt_reg    <= sample.elapsed_ms;
            learn_reg <= learn_c;
        end
    end

    // sequencer
    igdi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .mul_done (mul_done),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign sample.ready = ctrl.in_ready;

    // axis of the current op
    always_comb
    begin
        case (ctrl.op)
            OP_LP_Y, OP_VB_Y, OP_VD_Y: axis = 2'd1;
            OP_LP_Z, OP_VB_Z, OP_VD_Z: axis = 2'd2;
            default:                   axis = 2'd0;
        endcase
    end

    // low-pass operands: the update is x + round(alpha * (e - x) / 2^16)
    always_comb
    begin
        if (ctrl.op == OP_LP_DRIFT)
        begin
            lp_est = drift_reg;
            lp_x   = rate_reg;
        end
        else
        begin
            lp_est = grav_reg[axis];
            lp_x   = x_reg[axis];
        end
        lp_diff = {lp_est[FIX_W-1], lp_est} - {lp_x[FIX_W-1], lp_x};
    end

    assign one_minus_beta = Q_ONE - {1'b0, beta_reg};

    // multiplier operand select
    always_comb
    begin
        case (ctrl.op)
            OP_LP_X, OP_LP_Y, OP_LP_Z, OP_LP_DRIFT:
            begin
                mcand  = {{(MCAND_W-DIFF_W){lp_diff[DIFF_W-1]}}, lp_diff};
                mplier = {1'b0, alpha_reg};
            end
            OP_VB_X, OP_VB_Y, OP_VB_Z:
            begin
                mcand  = {{(MCAND_W-OUT_W){lin_reg[axis][OUT_W-1]}}, lin_reg[axis]};
                mplier = one_minus_beta;
            end
            OP_VD_X, OP_VD_Y, OP_VD_Z:
            begin
                mcand  = mul_prod[MCAND_W-1:0];
                mplier = MPLIER_W'(dt_reg);
            end
            OP_ANGLE:
            begin
                mcand  = {{(MCAND_W-OUT_W){corr_reg[OUT_W-1]}}, corr_reg};
                mplier = MPLIER_W'(dt_reg);
            end
            default:
            begin
                mcand  = '0;
                mplier = '0;
            end
        endcase
    end

    igdi_serial_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.start),
        .mcand  (mcand),
        .mplier (mplier),
        .busy   (mul_busy),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    // rounded shifts of the product and the sums built from them
    always_comb
    begin
        lp_t    = mul_prod[Q_W+DIFF_W-1:Q_W] + DIFF_W'(mul_prod[Q_W-1]);
        lp_new  = lp_x + lp_t[FIX_W-1:0];
        lp_lin  = ~lp_t + 1'b1;
        vd_inc  = mul_prod[Q_W+MCAND_W-1:Q_W] + MCAND_W'(mul_prod[Q_W-1]);
        vel_sum = {vel_reg[axis][SUM_W-1], vel_reg[axis]}
                + {{(SUM_W+1-MCAND_W){vd_inc[MCAND_W-1]}}, vd_inc};
        ang_sum = {angle_reg[SUM_W-1], angle_reg}
                + {{(SUM_W+1-MCAND_W){mul_prod[MCAND_W-1]}}, mul_prod[MCAND_W-1:0]};
    end

    // filter and integrator state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                grav_reg[i] <= '0;
                vel_reg[i]  <= '0;
            end
            drift_reg <= '0;
            angle_reg <= '0;
        end
        else if (ctrl.wb)
        begin
            case (ctrl.op)
                OP_LP_X, OP_LP_Y, OP_LP_Z:
                begin
                    grav_reg[axis] <= lp_new;
                end
                OP_LP_DRIFT:
                begin
                    if (learn_reg)
                    begin
                        drift_reg <= lp_new;
                    end
                end
                OP_VD_X, OP_VD_Y, OP_VD_Z:
                begin
                    vel_reg[axis] <= sat_sum(vel_sum);
                end
                OP_ANGLE:
                begin
                    angle_reg <= sat_sum(ang_sum);
                end
                default:
                begin
                end
            endcase
        end
    end

    // linear accel and corrected rate of the current sample
    always_ff @(posedge clk)
    begin
        if (ctrl.wb)
        begin
            case (ctrl.op)
                OP_LP_X, OP_LP_Y, OP_LP_Z:
                begin
                    lin_reg[axis] <= lp_lin;
                end
                OP_LP_DRIFT:
                begin
                    corr_reg <= learn_reg ? lp_lin : (~lp_diff + 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_lin_reg[i] <= lin_reg[i];
                out_vel_reg[i] <= vel_reg[i];
            end
            out_corr_reg  <= corr_reg;
            out_angle_reg <= angle_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.linear_accel_x = out_lin_reg[0];
    assign result.linear_accel_y = out_lin_reg[1];
    assign result.linear_accel_z = out_lin_reg[2];
    assign result.rate_corrected = out_corr_reg;
    assign result.velocity_x     = out_vel_reg[0];
    assign result.velocity_y     = out_vel_reg[1];
    assign result.velocity_z     = out_vel_reg[2];
    assign result.angle_sum      = out_angle_reg;

    `IGDI_ASSERT_IMP(a_ready_mul_idle, clk, rst_n, sample.ready, !mul_busy)
    `IGDI_ASSERT_IMP(a_wb_after_done, clk, rst_n, ctrl.wb, $past(mul_done))
    `IGDI_ASSERT_IMP(a_out_from_load, clk, rst_n, $rose(result.valid), $past(ctrl.out_load))

endmodule

// ===== tb/igdi_motion_scoreboard_pkg.sv =====
// sample and result types plus the scoreboard that predicts and checks each result
package igdi_motion_scoreboard_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    import igdi_pkg::*;

    // q0.16 weight arithmetic and 48-bit sum limits
    localparam longint WEIGHT_ONE   = 65536;
    localparam longint WEIGHT_HALF  = 32768;
    localparam longint SUM_HI       = longint'(48'sh7FFF_FFFF_FFFF);
    localparam longint SUM_LO       = -SUM_HI - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] rate;
        logic        [DT_W-1:0]     dt;
    } imu_sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] lin_x;
        logic signed [OUT_W-1:0] lin_y;
        logic signed [OUT_W-1:0] lin_z;
        logic signed [OUT_W-1:0] rate_corr;
        logic signed [SUM_W-1:0] vel_x;
        logic signed [SUM_W-1:0] vel_y;
        logic signed [SUM_W-1:0] vel_z;
        logic signed [SUM_W-1:0] angle;
    } motion_t;

    class motion_scoreboard;
        logic [CFG_DATA_W-1:0] alpha;
        logic [CFG_DATA_W-1:0] beta;
        logic [CFG_DATA_W-1:0] threshold;
        longint                gravity [3];
        longint                drift;
        longint                velocity [3];
        longint                angle;
        motion_t               expected_motion [$];
        int unsigned           failures;

        function new();
            alpha     = ALPHA_RESET;
            beta      = BETA_RESET;
            threshold = THR_RESET;
            for (int i = 0; i < 3; i++)
            begin
                gravity[i]  = 0;
                velocity[i] = 0;
            end
            drift    = 0;
            angle    = 0;
            failures = 0;
        endfunction

        // register write; indexes outside the map are dropped
        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GRAVITY_ALPHA:   alpha = value;
                CFG_VELOCITY_BETA:   beta = value;
                CFG_DRIFT_THRESHOLD: threshold = value;
                default: ;
            endcase
        endfunction

        // first-order low-pass step, rounded to nearest with floor
        function longint smooth(input longint est, input longint target);
            longint w;
            w = longint'(alpha);
            return (w * est + (WEIGHT_ONE - w) * target + WEIGHT_HALF) >>> Q_W;
        endfunction

        function longint clamp_sum(input longint v);
            if (v > SUM_HI)
                return SUM_HI;
            if (v < SUM_LO)
                return SUM_LO;
            return v;
        endfunction

        // advance the filters and integrators by one accepted sample
        function void take_sample(input imu_sample_t s);
            logic signed [SAMPLE_W-1:0] accel [3];
            longint                     fixed_in;
            longint                     lin [3];
            longint                     rate_fix;
            longint                     magnitude;
            longint                     corr;
            longint                     step;
            longint                     gain;
            longint                     inc;
            motion_t                    m;
            accel[0] = s.ax;
            accel[1] = s.ay;
            accel[2] = s.az;
            step     = longint'(s.dt);
            gain     = WEIGHT_ONE - longint'(beta);
            for (int i = 0; i < 3; i++)
            begin
                fixed_in    = longint'(accel[i]) <<< FRAC_BITS;
                gravity[i]  = smooth(gravity[i], fixed_in);
                lin[i]      = fixed_in - gravity[i];
                inc         = (gain * lin[i] * step + WEIGHT_HALF) >>> Q_W;
                velocity[i] = clamp_sum(velocity[i] + inc);
            end
            // drift learns only on quiet samples, then is removed
            magnitude = longint'(s.rate);
            if (magnitude < 0)
                magnitude = -magnitude;
            rate_fix = longint'(s.rate) <<< FRAC_BITS;
            if (magnitude < longint'(threshold))
                drift = smooth(drift, rate_fix);
            corr  = rate_fix - drift;
            angle = clamp_sum(angle + corr * step);

            m.lin_x     = OUT_W'(lin[0]);
            m.lin_y     = OUT_W'(lin[1]);
            m.lin_z     = OUT_W'(lin[2]);
            m.rate_corr = OUT_W'(corr);
            m.vel_x     = SUM_W'(velocity[0]);
            m.vel_y     = SUM_W'(velocity[1]);
            m.vel_z     = SUM_W'(velocity[2]);
            m.angle     = SUM_W'(angle);
            expected_motion.push_back(m);
        endfunction

        function void check_field(input string field, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_motion(input motion_t got);
            motion_t want;
            if (expected_motion.size() == 0)
            begin
                failures++;
                $display("%0t: result transfer with no sample outstanding", $time);
                return;
            end
            want = expected_motion.pop_front();
            check_field("linear_accel_x", want.lin_x, got.lin_x);
            check_field("linear_accel_y", want.lin_y, got.lin_y);
            check_field("linear_accel_z", want.lin_z, got.lin_z);
            check_field("rate_corrected", want.rate_corr, got.rate_corr);
            check_field("velocity_x", want.vel_x, got.vel_x);
            check_field("velocity_y", want.vel_y, got.vel_y);
            check_field("velocity_z", want.vel_z, got.vel_z);
            check_field("angle_sum", want.angle, got.angle);
        endfunction

        function int outstanding();
            return expected_motion.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_imu_gravity_drift_integrator.sv =====
// testbench top: random and directed imu samples checked against a running prediction
module tb_imu_gravity_drift_integrator;
    timeunit 1ns;
    timeprecision 1ps;
    import igdi_pkg::*;
    import igdi_motion_scoreboard_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 4000;
    localparam int                   SETTLE_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED   = 2'd3;

    typedef enum int {
        STYLE_STEADY,
        STYLE_NOISE,
        STYLE_EDGE,
        STYLE_PUSH
    } sample_style_t;

    logic             clk;
    logic             rst_n;
    int               send_idle_pct = 38;
    int               take_idle_pct = 60;
    int               base_gravity [3];
    motion_scoreboard board;

    igdi_sample_if sample_ch ();
    igdi_result_if result_ch ();
    igdi_cfg_if    cfg_ch ();

    imu_gravity_drift_integrator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random back-pressure, check every transfer
    initial
    begin
        motion_t got;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.lin_x     = result_ch.linear_accel_x;
                got.lin_y     = result_ch.linear_accel_y;
                got.lin_z     = result_ch.linear_accel_z;
                got.rate_corr = result_ch.rate_corrected;
                got.vel_x     = result_ch.velocity_x;
                got.vel_y     = result_ch.velocity_y;
                got.vel_z     = result_ch.velocity_z;
                got.angle     = result_ch.angle_sum;
                board.check_motion(got);
            end
            result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", quiet);
        $display("** imu_gravity_drift_integrator: FAILED **");
        $finish;
    end

    task automatic send_sample(input imu_sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.accel_x_raw <= s.ax;
        sample_ch.accel_y_raw <= s.ay;
        sample_ch.accel_z_raw <= s.az;
        sample_ch.rate_x_raw  <= s.rate;
        sample_ch.elapsed_ms  <= s.dt;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        board.take_sample(s);
    endtask

    task automatic send_fields(input int ax, input int ay, input int az, input int rate,
                               input int dt);
        imu_sample_t s;
        s.ax   = 16'(ax);
        s.ay   = 16'(ay);
        s.az   = 16'(az);
        s.rate = 16'(rate);
        s.dt   = 16'(dt);
        send_sample(s);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        board.set_reg(idx, value);
    endtask

    function automatic imu_sample_t make_sample(input sample_style_t style, input int dir);
        imu_sample_t s;
        int          thr_i;
        s     = '0;
        thr_i = int'(board.threshold);
        case (style)
            // at rest: gravity plus small noise, rate around the learning bound
            STYLE_STEADY:
            begin
                s.ax   = 16'(base_gravity[0] + int'($urandom_range(0, 1023)) - 512);
                s.ay   = 16'(base_gravity[1] + int'($urandom_range(0, 1023)) - 512);
                s.az   = 16'(base_gravity[2] + int'($urandom_range(0, 1023)) - 512);
                s.rate = 16'(int'($urandom_range(0, 2 * thr_i + 64)) - thr_i - 32);
                s.dt   = 16'($urandom_range(1, 40));
            end
            STYLE_NOISE:
            begin
                s.ax   = 16'($urandom);
                s.ay   = 16'($urandom);
                s.az   = 16'($urandom);
                s.rate = 16'($urandom);
                s.dt   = 16'($urandom);
            end
            // threshold boundaries, rate extremes, zero and full time step
            STYLE_EDGE:
            begin
                s.ax = 16'($urandom);
                s.ay = 16'($urandom);
                s.az = 16'($urandom);
                case ($urandom_range(0, 5))
                    0:       s.rate = 16'(thr_i - 1);
                    1:       s.rate = 16'(thr_i);
                    2:       s.rate = 16'(1 - thr_i);
                    3:       s.rate = 16'(-thr_i);
                    4:       s.rate = 16'h8000;
                    default: s.rate = 16'h7fff;
                endcase
                case ($urandom_range(0, 3))
                    0:       s.dt = 16'd0;
                    1:       s.dt = 16'd1;
                    2:       s.dt = 16'hffff;
                    default: s.dt = 16'($urandom);
                endcase
            end
            // full-scale one-sided motion to drive the sums into saturation
            default:
            begin
                if (dir > 0)
                begin
                    s.ax   = 16'(32767 - int'($urandom_range(0, 255)));
                    s.ay   = 16'(32767 - int'($urandom_range(0, 255)));
                    s.az   = 16'(32767 - int'($urandom_range(0, 255)));
                    s.rate = 16'(32767 - int'($urandom_range(0, 255)));
                end
                else
                begin
                    s.ax   = 16'(-32768 + int'($urandom_range(0, 255)));
                    s.ay   = 16'(-32768 + int'($urandom_range(0, 255)));
                    s.az   = 16'(-32768 + int'($urandom_range(0, 255)));
                    s.rate = 16'(-32768 + int'($urandom_range(0, 255)));
                end
                s.dt = 16'($urandom_range(60000, 65535));
            end
        endcase
        return s;
    endfunction

    // one setting: optional register writes, random samples, then drain
    task automatic run_phase(input bit write_regs, input logic [CFG_DATA_W-1:0] alpha,
                             input logic [CFG_DATA_W-1:0] beta,
                             input logic [CFG_DATA_W-1:0] thr, input int count,
                             input int push_pct, input int send_idle, input int take_idle);
        imu_sample_t   s;
        sample_style_t style;
        int            dir;
        int            roll;
        send_idle_pct = send_idle;
        take_idle_pct = take_idle;
        if (write_regs)
        begin
            write_reg(CFG_GRAVITY_ALPHA, alpha);
            write_reg(CFG_VELOCITY_BETA, beta);
            write_reg(CFG_DRIFT_THRESHOLD, thr);
            write_reg(CFG_UNMAPPED, 16'($urandom));
            cfg_ch.valid <= 1'b0;
        end
        for (int k = 0; k < 3; k++)
            base_gravity[k] = int'($urandom_range(0, 32767)) - 16384;
        for (int i = 0; i < count; i++)
        begin
            if (push_pct > 50)
                dir = (i < count * 2 / 5) ? 1 : -1;
            else
                dir = ($urandom_range(1) == 1) ? 1 : -1;
            if ($urandom_range(99) < push_pct)
                style = STYLE_PUSH;
            else
            begin
                roll = int'($urandom_range(99));
                if (roll < 50)
                    style = STYLE_STEADY;
                else if (roll < 80)
                    style = STYLE_NOISE;
                else
                    style = STYLE_EDGE;
            end
            s = make_sample(style, dir);
            send_sample(s);
        end
        sample_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board = new();
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.accel_x_raw <= '0;
        sample_ch.accel_y_raw <= '0;
        sample_ch.accel_z_raw <= '0;
        sample_ch.rate_x_raw  <= '0;
        sample_ch.elapsed_ms  <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples under the reset weights
        send_fields(0, 0, 0, 0, 0);
        send_fields(32767, 32767, 32767, 32767, 65535);
        send_fields(-32768, -32768, -32768, -32768, 65535);
        send_fields(1000, -1000, 16384, 1107, 10);
        send_fields(1000, -1000, 16384, 1108, 10);
        send_fields(1000, -1000, 16384, -1107, 10);
        send_fields(1000, -1000, 16384, -1108, 10);
        send_fields(0, 0, 0, 0, 1);
        send_fields(12345, -23456, 4096, 500, 0);
        send_fields(-1, 1, -1, -1, 65535);
        send_fields(16384, 0, -16384, 1107, 65535);
        send_fields(32767, -32768, 0, -32768, 0);
        send_fields(-32768, 32767, 1, 32767, 1);
        send_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        send_fields(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_fields(-16384, 8192, 16384, 0, 100);

        // sender slow and receiver slower
        run_phase(1'b0, '0, '0, '0, 250, 5, 38, 60);
        run_phase(1'b1, 16'd0, 16'd0, 16'd0, 250, 5, 38, 60);
        // roles swapped
        run_phase(1'b1, 16'hffff, 16'hffff, 16'hffff, 250, 5, 60, 38);
        run_phase(1'b1, 16'hffff, 16'd0, 16'd0, 700, 95, 60, 38);
        // full rate on both sides
        run_phase(1'b1, 16'($urandom), 16'($urandom), 16'd32768, 250, 10, 0, 0);
        run_phase(1'b1, ALPHA_RESET, 16'd32768, 16'($urandom_range(0, 2000)), 250, 5, 0, 0);

        // catch any stray result after the last one
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("** imu_gravity_drift_integrator: PASSED **");
        else
            $display("** imu_gravity_drift_integrator: FAILED **");
        $finish;
    end

endmodule
